// ===== rtl/strict_priority_queue_flow_control_assert.svh =====
// Assertion macros used by the top module of the priority queue.
`ifndef STRICT_PRIORITY_QUEUE_FLOW_CONTROL_ASSERT_SVH
`define STRICT_PRIORITY_QUEUE_FLOW_CONTROL_ASSERT_SVH

`ifndef SYNTHESIS

// Implication checked at every rising clock edge outside reset.
`define SPQFC_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define SPQFC_ASSERT_NEXT(lbl, clk_i, rstn_i, trig, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (trig) |=> (cons)) \
        else $error(msg);

`else

`define SPQFC_ASSERT(lbl, clk_i, rstn_i, prop, msg)
`define SPQFC_ASSERT_NEXT(lbl, clk_i, rstn_i, trig, cons, msg)

`endif

`endif

// ===== rtl/spqfc_pkg.sv =====
package spqfc_pkg;

    localparam int DEF_QUEUE_DEPTH = 1024;
    localparam int NUM_BANDS       = 4;
    localparam int BAND_W          = 2;
    localparam int TAG_WIDTH       = 16;
    localparam int PRIO_W          = 32;
    localparam int LEN_W           = 11;
    localparam int ENTRY_W         = TAG_WIDTH + PRIO_W;

    typedef enum logic [1:0] {
        KIND_ENQ   = 2'd0,
        KIND_DEQ   = 2'd1,
        KIND_PEEK  = 2'd2,
        KIND_FLUSH = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_DROP  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        LVL_ALL_OFF = 2'd0,
        LVL_RED_ON  = 2'd1,
        LVL_ALL_ON  = 2'd2
    } lvl_t;

    localparam logic [2:0] REG_MAX_QLEN = 3'd0;
    localparam logic [2:0] REG_RED_ON   = 3'd1;
    localparam logic [2:0] REG_RED_OFF  = 3'd2;
    localparam logic [2:0] REG_ALL_ON   = 3'd3;
    localparam logic [2:0] REG_ALL_OFF  = 3'd4;
    localparam logic [2:0] REG_NOTIFY   = 3'd5;

    typedef struct packed {
        logic [LEN_W-1:0] max_len;
        logic [LEN_W-1:0] red_on;
        logic [LEN_W-1:0] red_off;
        logic [LEN_W-1:0] all_on;
        logic [LEN_W-1:0] all_off;
        logic             notify;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        max_len: 11'd640,
        red_on:  11'd320,
        red_off: 11'd240,
        all_on:  11'd520,
        all_off: 11'd440,
        notify:  1'b0
    };

    // Result of the decision stage, waiting for the store's read data.
    typedef struct packed {
        status_t           status;
        logic [BAND_W-1:0] band;
        logic              fc_signal;
        lvl_t              fc_level;
        logic              use_rd;
        logic [PRIO_W-1:0] enq_prio;
    } pend_t;

    typedef struct packed {
        status_t              status;
        logic [TAG_WIDTH-1:0] tag;
        logic [PRIO_W-1:0]    prio;
        logic [BAND_W-1:0]    band;
        logic                 fc_signal;
        lvl_t                 fc_level;
    } res_t;

    function automatic logic [BAND_W-1:0] band_map(input logic [3:0] p);
        logic [BAND_W-1:0] b;
        case (p)
            4'd0:    b = 2'd2;
            4'd1:    b = 2'd3;
            4'd2:    b = 2'd3;
            4'd3:    b = 2'd2;
            4'd4:    b = 2'd1;
            4'd5:    b = 2'd1;
            4'd6:    b = 2'd0;
            4'd7:    b = 2'd0;
            default: b = 2'd1;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/spqfc_store.sv =====
module spqfc_store #(
    parameter int AW = 12,
    parameter int DW = 48
) (
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/spqfc_ctrl.sv =====
module spqfc_ctrl #(
    parameter int QUEUE_DEPTH = spqfc_pkg::DEF_QUEUE_DEPTH,
    parameter int AW          = $clog2(QUEUE_DEPTH) + spqfc_pkg::BAND_W
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        accept,
    input  spqfc_pkg::kind_t                            kind,
    input  logic [spqfc_pkg::TAG_WIDTH-1:0]             packet_tag,
    input  logic [spqfc_pkg::PRIO_W-1:0]                priority_req,
    input  spqfc_pkg::cfg_t                             cfg,
    output logic                                        mem_we,
    output logic                                        mem_re,
    output logic [AW-1:0]                               mem_addr,
    output logic [spqfc_pkg::ENTRY_W-1:0]               mem_wdata,
    output spqfc_pkg::pend_t                            pend
);

    import spqfc_pkg::*;

    localparam int PW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (CW > LEN_W) ? CW : LEN_W;

    logic [PW-1:0] head_reg  [NUM_BANDS];
    logic [PW-1:0] head_next [NUM_BANDS];
    logic [PW-1:0] tail_reg  [NUM_BANDS];
    logic [PW-1:0] tail_next [NUM_BANDS];
    logic [CW-1:0] count_reg [NUM_BANDS];
    logic [CW-1:0] count_next[NUM_BANDS];
    lvl_t          level_reg [NUM_BANDS];
    lvl_t          level_next[NUM_BANDS];

    logic [BAND_W-1:0] band_enq;
    logic [BAND_W-1:0] band_deq;
    logic [BAND_W-1:0] sel_band;
    logic              any_nonempty;
    logic [CW-1:0]     qlen;
    lvl_t              lvl;
    logic [CMPW-1:0]   qx;
    logic [CMPW-1:0]   qdec;
    logic [CMPW-1:0]   max_x;
    logic [CMPW-1:0]   red_on_x;
    logic [CMPW-1:0]   red_off_x;
    logic [CMPW-1:0]   all_on_x;
    logic [CMPW-1:0]   all_off_x;
    logic              full;
    logic [PW-1:0]     ptr;
    logic [PW-1:0]     ptr_inc;

    assign band_enq = band_map(priority_req[3:0]);

    // Lowest numbered band that holds a packet.
    always_comb
    begin
        band_deq     = '0;
        any_nonempty = 1'b0;
        for (int b = NUM_BANDS - 1; b >= 0; b--)
        begin
            if (count_reg[b] != '0)
            begin
                band_deq     = BAND_W'(b);
                any_nonempty = 1'b1;
            end
        end
    end

    assign sel_band  = (kind == KIND_ENQ) ? band_enq : band_deq;
    assign qlen      = count_reg[sel_band];
    assign lvl       = level_reg[sel_band];
    assign qx        = CMPW'(qlen);
    assign qdec      = qx - CMPW'(1);
    assign max_x     = CMPW'(cfg.max_len);
    assign red_on_x  = CMPW'(cfg.red_on);
    assign red_off_x = CMPW'(cfg.red_off);
    assign all_on_x  = CMPW'(cfg.all_on);
    assign all_off_x = CMPW'(cfg.all_off);
    assign full      = (qx >= max_x) || (qx >= CMPW'(QUEUE_DEPTH));

    assign ptr       = (kind == KIND_ENQ) ? tail_reg[sel_band] : head_reg[sel_band];
    assign ptr_inc   = (ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : ptr + PW'(1);
    assign mem_addr  = {sel_band, ptr};
    assign mem_wdata = {priority_req, packet_tag};

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        level_next = level_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        pend       = '0;

        case (kind)
            KIND_ENQ:
            begin
                pend.band     = band_enq;
                pend.fc_level = lvl;
                if (full)
                begin
                    pend.status = ST_DROP;
                end
                else
                begin
                    pend.status = ST_DONE;
                    if (qx >= red_on_x)
                    begin
                        if (qx < all_off_x && lvl != LVL_RED_ON)
                        begin
                            level_next[band_enq] = LVL_RED_ON;
                            pend.fc_level        = LVL_RED_ON;
                            pend.fc_signal       = cfg.notify;
                        end
                        else if (qx >= all_on_x && lvl != LVL_ALL_ON)
                        begin
                            level_next[band_enq] = LVL_ALL_ON;
                            pend.fc_level        = LVL_ALL_ON;
                            pend.fc_signal       = cfg.notify;
                        end
                    end
                    pend.enq_prio        = pend.fc_signal ? priority_req : '0;
                    mem_we               = accept;
                    tail_next[band_enq]  = ptr_inc;
                    count_next[band_enq] = qlen + CW'(1);
                end
            end

            KIND_DEQ, KIND_PEEK:
            begin
                if (!any_nonempty)
                begin
                    pend.status = ST_EMPTY;
                end
                else
                begin
                    pend.status   = ST_DONE;
                    pend.band     = band_deq;
                    pend.use_rd   = 1'b1;
                    pend.fc_level = lvl;
                    mem_re        = accept;
                    if (kind == KIND_DEQ)
                    begin
                        head_next[band_deq]  = ptr_inc;
                        count_next[band_deq] = qlen - CW'(1);
                        // Hysteresis: going off has precedence over red only.
                        if (qdec <= red_off_x && lvl != LVL_ALL_OFF)
                        begin
                            level_next[band_deq] = LVL_ALL_OFF;
                            pend.fc_level        = LVL_ALL_OFF;
                            pend.fc_signal       = cfg.notify;
                        end
                        else if (qdec >= red_on_x && qdec <= all_off_x && lvl != LVL_RED_ON)
                        begin
                            level_next[band_deq] = LVL_RED_ON;
                            pend.fc_level        = LVL_RED_ON;
                            pend.fc_signal       = cfg.notify;
                        end
                    end
                end
            end

            KIND_FLUSH:
            begin
                for (int b = 0; b < NUM_BANDS; b++)
                begin
                    head_next[b]  = '0;
                    tail_next[b]  = '0;
                    count_next[b] = '0;
                    level_next[b] = LVL_ALL_OFF;
                end
            end

            default:
            begin
                pend = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BANDS; b++)
            begin
                head_reg[b]  <= '0;
                tail_reg[b]  <= '0;
                count_reg[b] <= '0;
                level_reg[b] <= LVL_ALL_OFF;
            end
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            level_reg <= level_next;
        end
    end

endmodule

// ===== rtl/strict_priority_queue_flow_control.sv =====
// Strict-priority four-band packet queue with hysteresis flow control.
// Items enter on the s_ stream: tuser carries the operation (enqueue, dequeue,
// peek, flush), tdata the packet tag and priority. Every item yields exactly
// one result item on the m_ stream, with status in tuser and tag, priority,
// band and flow-control signal and level in tdata.
// An accepted item waits in the pending stage until the output register is empty
// or being taken, then its result moves there. Band pointers, counts and levels
// are updated at the edge that accepts an item, and the packet store (one
// synchronous memory) is read or written at that edge; its registered read
// data completes the result in the next cycle. A new item can be taken every
// cycle, so the sustained rate is one item per cycle while the receiver keeps up.
// When the receiver stalls, one result waits in the output register and one
// more in the pending stage; s_tready then drops until the output moves.
// Reset empties all bands, clears the levels and returns the configuration
// registers to their defaults at once; the packet store needs no clearing, since
// only slots holding packets are read. Configuration must be written by the user
// through the APB port while no item is in flight; the block does not enforce it.
module strict_priority_queue_flow_control #(
    parameter int QUEUE_DEPTH = spqfc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // packet_tag[15:0], priority_req[47:16]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_tag[15:0], out_priority[47:16], out_band[49:48],
                                   // fc_signal[50], fc_level[52:51], zero pad[55:53]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import spqfc_pkg::*;

    `include "strict_priority_queue_flow_control_assert.svh"

    localparam int AW = $clog2(QUEUE_DEPTH) + BAND_W;

    cfg_t  cfg_reg;
    logic  cfg_wr;

    logic  accept;
    logic  move;
    kind_t kind;

    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] rd_data;

    pend_t pend;
    pend_t pend_reg;
    logic  pend_valid_reg;
    res_t  out_reg;
    res_t  out_next;
    logic  out_valid_reg;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_MAX_QLEN: cfg_reg.max_len <= pwdata[LEN_W-1:0];
                REG_RED_ON:   cfg_reg.red_on  <= pwdata[LEN_W-1:0];
                REG_RED_OFF:  cfg_reg.red_off <= pwdata[LEN_W-1:0];
                REG_ALL_ON:   cfg_reg.all_on  <= pwdata[LEN_W-1:0];
                REG_ALL_OFF:  cfg_reg.all_off <= pwdata[LEN_W-1:0];
                REG_NOTIFY:   cfg_reg.notify  <= pwdata[0];
                default:      cfg_reg         <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_MAX_QLEN: prdata = 32'(cfg_reg.max_len);
            REG_RED_ON:   prdata = 32'(cfg_reg.red_on);
            REG_RED_OFF:  prdata = 32'(cfg_reg.red_off);
            REG_ALL_ON:   prdata = 32'(cfg_reg.all_on);
            REG_ALL_OFF:  prdata = 32'(cfg_reg.all_off);
            REG_NOTIFY:   prdata = 32'(cfg_reg.notify);
            default:      prdata = '0;
        endcase
    end

    // Item flow: decision stage, pending stage, output register.
    assign move     = pend_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !pend_valid_reg || move;
    assign accept   = s_tvalid && s_tready;
    assign kind     = kind_t'(s_tuser);

    spqfc_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .kind         (kind),
        .packet_tag   (s_tdata[TAG_WIDTH-1:0]),
        .priority_req (s_tdata[TAG_WIDTH+PRIO_W-1:TAG_WIDTH]),
        .cfg          (cfg_reg),
        .mem_we       (mem_we),
        .mem_re       (mem_re),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .pend         (pend)
    );

    spqfc_store #(
        .AW (AW),
        .DW (ENTRY_W)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .re      (mem_re),
        .addr    (mem_addr),
        .wdata   (mem_wdata),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= pend;
        end
        if (move)
        begin
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        out_next.status    = pend_reg.status;
        out_next.band      = pend_reg.band;
        out_next.fc_signal = pend_reg.fc_signal;
        out_next.fc_level  = pend_reg.fc_level;
        if (pend_reg.use_rd)
        begin
            out_next.tag  = rd_data[TAG_WIDTH-1:0];
            out_next.prio = rd_data[ENTRY_W-1:TAG_WIDTH];
        end
        else
        begin
            out_next.tag  = '0;
            out_next.prio = pend_reg.enq_prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {3'b000, out_reg.fc_level, out_reg.fc_signal, out_reg.band,
                       out_reg.prio, out_reg.tag};

    `SPQFC_ASSERT_NEXT(a_accept_pends, clk, rst_n, accept, pend_valid_reg, "accepted item not pending")
    `SPQFC_ASSERT(a_stall_blocks, clk, rst_n, (pend_valid_reg && out_valid_reg && !m_tready) |-> !s_tready, "input taken while both stages are full")
    `SPQFC_ASSERT(a_drop_silent, clk, rst_n, (out_valid_reg && out_reg.status == ST_DROP) |-> !out_reg.fc_signal, "dropped item signals flow control")
    `SPQFC_ASSERT(a_signal_enabled, clk, rst_n, (out_valid_reg && out_reg.fc_signal) |-> cfg_reg.notify, "flow control signalled while notification is off")
    `SPQFC_ASSERT(a_empty_zero, clk, rst_n, (out_valid_reg && out_reg.status == ST_EMPTY) |-> (out_reg.band == '0 && out_reg.fc_level == LVL_ALL_OFF), "empty result carries band or level")

endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spqfc_pkg::*;

    // Priority nibble to band, band 0 being served first.
    localparam logic [1:0] PRIO_BAND [16] = '{
        2'd2, 2'd3, 2'd3, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1
    };

    typedef struct packed {
        logic [TAG_WIDTH-1:0] tag;
        logic [PRIO_W-1:0]    prio;
    } pkt_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;     // packet_tag[15:0], priority_req[47:16]
    logic [1:0]  s_tuser = '0;     // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;          // out_tag[15:0], out_priority[47:16], out_band[49:48],
                                   // fc_signal[50], fc_level[52:51]
    logic [1:0]  m_tuser;          // status[1:0]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Model of the queue: one packet FIFO and one level per band.
    pkt_t band_pkts [NUM_BANDS][$];
    lvl_t band_lvl [NUM_BANDS] = '{LVL_ALL_OFF, LVL_ALL_OFF, LVL_ALL_OFF, LVL_ALL_OFF};
    cfg_t model_cfg = CFG_RESET;

    res_t expected_replies [$];
    int   mismatches = 0;
    bit   idle_on = 1'b1;
    int   rx_hold = 0;
    int   rx_gap = 0;

    strict_priority_queue_flow_control i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void note_mismatch(string what, longint unsigned want,
                                          longint unsigned got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
        end
    endfunction

    // Mostly no gap or a short one, now and then a long one; no gaps while idle_on is clear.
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic res_t apply_queue_op(kind_t op, logic [15:0] tag, logic [31:0] prio);
        res_t r;
        int   b;
        int   i;
        int   n;
        logic sig;
        pkt_t pkt;
        r = '0;
        sig = 1'b0;
        case (op)
            KIND_ENQ:
            begin
                b = int'(PRIO_BAND[prio[3:0]]);
                n = band_pkts[b].size();
                r.band = 2'(b);
                if (n >= int'(model_cfg.max_len) || n >= DEF_QUEUE_DEPTH)
                begin
                    r.status = ST_DROP;
                end
                else
                begin
                    // On an enqueue the level may move to red or all-on, judged by the length before it.
                    if (n >= int'(model_cfg.red_on))
                    begin
                        if (n < int'(model_cfg.all_off) && band_lvl[b] != LVL_RED_ON)
                        begin
                            band_lvl[b] = LVL_RED_ON;
                            sig = model_cfg.notify;
                        end
                        else if (n >= int'(model_cfg.all_on) && band_lvl[b] != LVL_ALL_ON)
                        begin
                            band_lvl[b] = LVL_ALL_ON;
                            sig = model_cfg.notify;
                        end
                    end
                    pkt.tag = tag;
                    pkt.prio = prio;
                    band_pkts[b].push_back(pkt);
                    r.fc_signal = sig;
                    if (sig)
                    begin
                        r.prio = prio;
                    end
                end
                r.fc_level = band_lvl[b];
            end
            KIND_FLUSH:
            begin
                for (i = 0; i < NUM_BANDS; i++)
                begin
                    band_pkts[i].delete();
                    band_lvl[i] = LVL_ALL_OFF;
                end
            end
            default:
            begin
                b = -1;
                for (i = NUM_BANDS - 1; i >= 0; i--)
                begin
                    if (band_pkts[i].size() != 0)
                    begin
                        b = i;
                    end
                end
                if (b < 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    pkt = band_pkts[b][0];
                    r.tag = pkt.tag;
                    r.prio = pkt.prio;
                    r.band = 2'(b);
                    if (op == KIND_DEQ)
                    begin
                        void'(band_pkts[b].pop_front());
                        n = band_pkts[b].size();
                        if (n <= int'(model_cfg.red_off) && band_lvl[b] != LVL_ALL_OFF)
                        begin
                            band_lvl[b] = LVL_ALL_OFF;
                            sig = model_cfg.notify;
                        end
                        else if (n >= int'(model_cfg.red_on) && n <= int'(model_cfg.all_off)
                                 && band_lvl[b] != LVL_RED_ON)
                        begin
                            band_lvl[b] = LVL_RED_ON;
                            sig = model_cfg.notify;
                        end
                        r.fc_signal = sig;
                    end
                    r.fc_level = band_lvl[b];
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_op(kind_t op, logic [15:0] tag, logic [31:0] prio);
        int gap;
        gap = gap_cycles();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {prio, tag};
        do @(posedge clk); while (!s_tready);
        expected_replies.push_back(apply_queue_op(op, tag, prio));
    endtask

    // Stops offering items and waits until every result is back.
    task automatic wait_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        logic [31:0] mask;
        mask = (idx == REG_NOTIFY) ? 32'h1 : 32'h7ff;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_MAX_QLEN: model_cfg.max_len = val[LEN_W-1:0];
            REG_RED_ON:   model_cfg.red_on = val[LEN_W-1:0];
            REG_RED_OFF:  model_cfg.red_off = val[LEN_W-1:0];
            REG_ALL_ON:   model_cfg.all_on = val[LEN_W-1:0];
            REG_ALL_OFF:  model_cfg.all_off = val[LEN_W-1:0];
            REG_NOTIFY:   model_cfg.notify = val[0];
            default:      ;
        endcase
        // Read the register straight back.
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if ((prdata & mask) !== (val & mask))
        begin
            note_mismatch("register readback", val & mask, prdata & mask);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_config(cfg_t c);
        write_reg(REG_MAX_QLEN, 32'(c.max_len));
        write_reg(REG_RED_ON, 32'(c.red_on));
        write_reg(REG_RED_OFF, 32'(c.red_off));
        write_reg(REG_ALL_ON, 32'(c.all_on));
        write_reg(REG_ALL_OFF, 32'(c.all_off));
        write_reg(REG_NOTIFY, 32'(c.notify));
    endtask

    task automatic test_band_mapping();
        int          i;
        logic [15:0] tag;
        logic [31:0] prio;
        for (i = 0; i < 16; i++)
        begin
            tag = 16'($urandom);
            prio = $urandom;
            prio[3:0] = 4'(i);
            if (i == 0)
            begin
                prio = 32'h0;
            end
            if (i == 6)
            begin
                tag = 16'h0000;
                prio = 32'h0000_0006;
            end
            if (i == 7)
            begin
                tag = 16'hffff;
                prio = 32'hffff_fff7;
            end
            send_op(KIND_ENQ, tag, prio);
        end
        send_op(KIND_PEEK, 16'hffff, 32'hffff_ffff);
        repeat (4) send_op(KIND_DEQ, 16'($urandom), $urandom);
        send_op(KIND_FLUSH, 16'($urandom), $urandom);
        send_op(KIND_DEQ, 16'h0000, 32'h0);
        send_op(KIND_PEEK, 16'h0000, 32'h0);
    endtask

    task automatic test_flow_control_phases();
        cfg_t        c;
        int          p;
        int          i;
        int          r;
        int          run_left;
        int          n_items;
        bit          filling;
        logic [3:0]  focus;
        logic [31:0] prio;
        kind_t       op;
        filling = 1'b0;
        focus = 4'h0;
        for (p = 0; p < 9; p++)
        begin
            wait_drain();
            case (p)
                0: c = '{max_len: 11'd10, red_on: 11'd0, red_off: 11'd0, all_on: 11'd0,
                         all_off: 11'd0, notify: 1'b1};
                1: c = '{max_len: 11'd1024, red_on: 11'd1024, red_off: 11'd1024,
                         all_on: 11'd1024, all_off: 11'd1024, notify: 1'b0};
                2: c = '{max_len: 11'd0, red_on: 11'd2, red_off: 11'd1, all_on: 11'd4,
                         all_off: 11'd3, notify: 1'b1};
                default:
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        // Ordered thresholds, the usual hysteresis shape.
                        c.red_off = 11'($urandom_range(0, 4));
                        c.red_on = c.red_off + 11'($urandom_range(1, 4));
                        c.all_off = c.red_on + 11'($urandom_range(1, 4));
                        c.all_on = c.all_off + 11'($urandom_range(1, 4));
                        c.max_len = c.all_on + 11'($urandom_range(0, 6));
                    end
                    else
                    begin
                        c.max_len = 11'($urandom_range(0, 24));
                        c.red_on = 11'($urandom_range(0, 20));
                        c.red_off = 11'($urandom_range(0, 20));
                        c.all_on = 11'($urandom_range(0, 20));
                        c.all_off = 11'($urandom_range(0, 20));
                    end
                    c.notify = 1'($urandom_range(0, 1));
                end
            endcase
            program_config(c);
            idle_on = (p % 3 != 2);
            n_items = (p == 2) ? 15 : 40;
            run_left = 0;
            for (i = 0; i < n_items; i++)
            begin
                if (run_left == 0)
                begin
                    filling = ~filling;
                    run_left = $urandom_range(4, 24);
                    focus = 4'($urandom_range(0, 15));
                end
                run_left--;
                r = $urandom_range(0, 99);
                if (r < (filling ? 75 : 20))
                begin
                    op = KIND_ENQ;
                end
                else if (r < (filling ? 90 : 85))
                begin
                    op = KIND_DEQ;
                end
                else if (r < 98)
                begin
                    op = KIND_PEEK;
                end
                else
                begin
                    op = KIND_FLUSH;
                end
                prio = $urandom;
                if ($urandom_range(0, 9) < 7)
                begin
                    prio[3:0] = focus;
                end
                send_op(op, 16'($urandom), prio);
            end
        end
        idle_on = 1'b1;
    endtask

    // Fills one band to the full depth while the receiver holds off at first, so the
    // block backs up into its input, then drains part of it and refills.
    task automatic test_full_band_backpressure();
        cfg_t        c;
        int          i;
        logic [3:0]  nib;
        logic [31:0] prio;
        wait_drain();
        c = '{max_len: 11'd1024, red_on: 11'd1000, red_off: 11'd990, all_on: 11'd1020,
              all_off: 11'd1010, notify: 1'b1};
        program_config(c);
        send_op(KIND_FLUSH, 16'($urandom), $urandom);
        nib = 4'($urandom_range(0, 15));
        rx_hold = 400;
        for (i = 0; i < 1030; i++)
        begin
            prio = $urandom;
            prio[3:0] = nib;
            send_op(KIND_ENQ, 16'($urandom), prio);
        end
        for (i = 0; i < 24; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                send_op(KIND_PEEK, 16'($urandom), $urandom);
            end
            else
            begin
                send_op(KIND_DEQ, 16'($urandom), $urandom);
            end
        end
        for (i = 0; i < 12; i++)
        begin
            prio = $urandom;
            prio[3:0] = nib;
            send_op(KIND_ENQ, 16'($urandom), prio);
        end
        repeat (3) send_op(KIND_DEQ, 16'($urandom), $urandom);
        send_op(KIND_FLUSH, 16'($urandom), $urandom);
        wait_drain();
    endtask

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else if (rx_gap > 0)
        begin
            m_tready <= 1'b0;
            rx_gap = rx_gap - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_gap = gap_cycles();
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = status_t'(m_tuser);
            got.tag = m_tdata[15:0];
            got.prio = m_tdata[47:16];
            got.band = m_tdata[49:48];
            got.fc_signal = m_tdata[50];
            got.fc_level = lvl_t'(m_tdata[52:51]);
            if (expected_replies.size() == 0)
            begin
                note_mismatch("result item with nothing expected", 0, {m_tuser, m_tdata});
            end
            else
            begin
                want = expected_replies.pop_front();
                if (got.status !== want.status)
                    note_mismatch("status", want.status, got.status);
                if (got.tag !== want.tag)
                    note_mismatch("out_tag", want.tag, got.tag);
                if (got.prio !== want.prio)
                    note_mismatch("out_priority", want.prio, got.prio);
                if (got.band !== want.band)
                    note_mismatch("out_band", want.band, got.band);
                if (got.fc_signal !== want.fc_signal)
                    note_mismatch("fc_signal", want.fc_signal, got.fc_signal);
                if (got.fc_level !== want.fc_level)
                    note_mismatch("fc_level", want.fc_level, got.fc_level);
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_band_mapping();
        test_flow_control_phases();
        test_full_band_backpressure();
        wait_drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== strict_priority_queue_flow_control.f =====
+incdir+rtl
rtl/spqfc_pkg.sv
rtl/spqfc_store.sv
rtl/spqfc_ctrl.sv
rtl/strict_priority_queue_flow_control.sv
sim/testbench.sv
